[rtl/edd_pkg.sv]
// edd_pkg: shared codes, widths and types of the edit distance engine.
// No dependencies; imported by every other file of the block.
`default_nettype none

package edd_pkg;

  localparam int DEF_MAX_LEN = 64;
  localparam int OP_W        = 2;
  localparam int CH_W        = 8;
  localparam int DIST_W      = 7;
  localparam int STATUS_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_FIRST  = 2'd0,
    OP_SECOND = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_ORDER    = 2'd3
  } status_t;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PRIME = 4'b0010,
    S_WALK  = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

endpackage

`default_nettype wire

[rtl/edd_in_if.sv]
// edd_in_if: valid/ready channel carrying one command item (op, ch).
// Depends on edd_pkg for field widths.
`default_nettype none

interface edd_in_if
  import edd_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op;
  logic [CH_W-1:0] ch;

  modport source (output valid, output op, output ch, input ready);
  modport sink   (input valid, input op, input ch, output ready);
endinterface

`default_nettype wire

[rtl/edd_out_if.sv]
// edd_out_if: valid/ready channel carrying one result item (distance, status).
// Depends on edd_pkg for field widths.
`default_nettype none

interface edd_out_if
  import edd_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [DIST_W-1:0]   distance;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output distance, output status, input ready);
  modport sink   (input valid, input distance, input status, output ready);
endinterface

`default_nettype wire

[rtl/edd_step_unit.sv]
// edd_step_unit: shared DP cell, min of (above+1, left+1, diag+cost).
// Depends on edd_pkg for the byte width.
`default_nettype none

module edd_step_unit
  import edd_pkg::*;
#(
  parameter int VW = 7
) (
  input  wire logic [VW-1:0]   above,
  input  wire logic [VW-1:0]   left,
  input  wire logic [VW-1:0]   diag,
  input  wire logic [CH_W-1:0] a_byte,
  input  wire logic [CH_W-1:0] b_byte,
  output logic      [VW-1:0]   result
);

  logic [VW:0] up_c;
  logic [VW:0] left_c;
  logic [VW:0] diag_c;
  logic [VW:0] m;

  always_comb begin
    up_c   = {1'b0, above} + 1'b1;
    left_c = {1'b0, left} + 1'b1;
    diag_c = {1'b0, diag} + {{VW{1'b0}}, (a_byte != b_byte)};
    m = up_c;
    if (left_c < m) m = left_c;
    if (diag_c < m) m = diag_c;
    // a row entry never exceeds the max length, so the top bit is zero
    result = m[VW-1:0];
  end

endmodule

`default_nettype wire

[rtl/edit_distance_engine.sv]
// Levenshtein distance engine: a first-string byte is stored while idle; a
// second-string byte runs a row prime, then one DP entry per cycle through the
// shared step unit and the one-read, one-write row memory; finish passes through the
// result state and presents its result item from a register; one item is in work
// at a time, and input also waits while a result item is held unaccepted.
// Reset (rst, synchronous) clears lengths, error code, sequencer and output valid.
`default_nettype none

module edit_distance_engine
  import edd_pkg::*;
#(
  parameter int MAX_LEN = DEF_MAX_LEN
) (
  input  wire logic clk,
  input  wire logic rst,
  edd_in_if.sink    cmd,
  edd_out_if.source res
);

  localparam int LW  = $clog2(MAX_LEN + 1);   // lengths, row addresses, row values
  localparam int FAW = $clog2(MAX_LEN);       // string buffer address
  localparam int DW  = (LW > DIST_W) ? LW : DIST_W;
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);

  state_t          state;
  logic [LW-1:0]   first_length;
  logic [LW-1:0]   second_length;
  logic [1:0]      error_code;
  logic            out_valid;
  logic [DIST_W-1:0]   out_distance;
  logic [STATUS_W-1:0] out_status;

  logic [CH_W-1:0] byte_q;
  logic [LW-1:0]   left;
  logic [LW-1:0]   diag;
  logic [LW-1:0]   idx;

  logic [CH_W-1:0] fs_mem [MAX_LEN];
  logic [LW-1:0]   dp_mem [MAX_LEN+1];
  logic [CH_W-1:0] fs_rd;
  logic [LW-1:0]   dp_rd;

  logic            in_ready;
  logic            acc;
  logic            fs_we;
  logic [FAW-1:0]  fs_waddr;
  logic [FAW-1:0]  fs_raddr;
  logic            dp_we;
  logic [LW-1:0]   dp_waddr;
  logic [LW-1:0]   dp_wdata;
  logic [LW-1:0]   dp_raddr;
  logic [LW-1:0]   above;
  logic [LW-1:0]   cell_out;
  logic [LW-1:0]   row_start;
  logic [DW-1:0]   dist_ext;

  edd_step_unit #(.VW(LW)) u_step (
    .above  (above),
    .left   (left),
    .diag   (diag),
    .a_byte (fs_rd),
    .b_byte (byte_q),
    .result (cell_out)
  );

  always_comb begin
    in_ready  = (state == S_IDLE) && (!out_valid || res.ready);
    acc       = cmd.valid && in_ready;
    row_start = LW'(second_length + 1'b1);
    // first row of the table is 0..n, so memory contents are not used then
    above     = (second_length == '0) ? idx : dp_rd;
    dist_ext  = DW'(dp_rd);

    fs_we    = acc && (cmd.op == OP_FIRST) && (second_length == '0) &&
               (first_length < LEN_MAX);
    fs_waddr = first_length[FAW-1:0];
    fs_raddr = '0;
    dp_we    = 1'b0;
    dp_waddr = '0;
    dp_wdata = row_start;
    dp_raddr = '0;

    unique case (state)
      S_IDLE: begin
        if (cmd.op == OP_FINISH) dp_raddr = first_length;
      end
      S_PRIME: begin
        dp_we    = 1'b1;
        dp_raddr = (first_length == '0) ? '0 : LW'(1);
      end
      S_WALK: begin
        dp_we    = 1'b1;
        dp_waddr = idx;
        dp_wdata = cell_out;
        if (idx != first_length) begin
          dp_raddr = LW'(idx + 1'b1);
          fs_raddr = idx[FAW-1:0];
        end
      end
      S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[fs_waddr] <= cmd.ch;
    fs_rd <= fs_mem[fs_raddr];
  end

  always_ff @(posedge clk) begin
    if (dp_we) dp_mem[dp_waddr] <= dp_wdata;
    dp_rd <= dp_mem[dp_raddr];
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      first_length  <= '0;
      second_length <= '0;
      error_code    <= ST_OK;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && res.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            case (cmd.op)
              OP_FIRST: begin
                if (second_length != '0) begin
                  if (error_code == ST_OK) error_code <= ST_ORDER;
                end else if (first_length >= LEN_MAX) begin
                  if (error_code == ST_OK) error_code <= ST_OVERFLOW;
                end else begin
                  first_length <= LW'(first_length + 1'b1);
                end
              end
              OP_SECOND: begin
                if (second_length >= LEN_MAX) begin
                  if (error_code == ST_OK) error_code <= ST_OVERFLOW;
                end else begin
                  state <= S_PRIME;
                end
              end
              OP_FINISH: state <= S_FIN;
              default: begin
              end
            endcase
          end
        end
        S_PRIME: begin
          if (first_length == '0) begin
            second_length <= row_start;
            state         <= S_IDLE;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (idx == first_length) begin
            second_length <= row_start;
            state         <= S_IDLE;
          end
        end
        S_FIN: begin
          out_valid     <= 1'b1;
          first_length  <= '0;
          second_length <= '0;
          error_code    <= ST_OK;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (acc) byte_q <= cmd.ch;
      end
      S_PRIME: begin
        diag <= (second_length == '0) ? '0 : dp_rd;
        left <= row_start;
        idx  <= LW'(1);
      end
      S_WALK: begin
        left <= cell_out;
        diag <= above;
        idx  <= LW'(idx + 1'b1);
      end
      S_FIN: begin
        if (error_code != ST_OK) begin
          out_status   <= error_code;
          out_distance <= '0;
        end else if (first_length == '0 || second_length == '0) begin
          out_status   <= ST_EMPTY;
          out_distance <= '0;
        end else begin
          out_status   <= ST_OK;
          out_distance <= dist_ext[DIST_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign cmd.ready    = in_ready;
  assign res.valid    = out_valid;
  assign res.distance = out_distance;
  assign res.status   = out_status;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (first_length <= LEN_MAX) && (second_length <= LEN_MAX))
    else $error("string length beyond max");

  a_walk_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (idx != '0) && (idx <= first_length))
    else $error("row walk index out of range");

  a_fin_follows: assert property (@(posedge clk) disable iff (rst)
    (acc && cmd.op == OP_FINISH) |=> (state == S_FIN))
    else $error("finish item did not reach result state");

  a_err_dist: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status != ST_OK) |-> (res.distance == '0))
    else $error("nonzero distance with error status");
`endif

endmodule

`default_nettype wire
